@@ design/assert_macros.svh @@
// Assertion macros used by the RTL of the request scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

@@ design/prs_pkg.sv @@
//------------------------------------------------------------------------------
// prs_pkg
// Shared codes, types and constants of the priority request scheduler.
//------------------------------------------------------------------------------
`default_nettype none

package prs_pkg;

   // Largest supported queue depth and the fixed index widths that follow.
   localparam int MAX_DEPTH     = 256;
   localparam int IDX_W         = 8;
   localparam int CNT_W         = 9;
   localparam int DEPTH_DEFAULT = 16;

   // Request codes.
   localparam logic [2:0] FN_SUBMIT     = 3'd0;
   localparam logic [2:0] FN_CANCEL     = 3'd1;
   localparam logic [2:0] FN_CANCEL_ALL = 3'd2;
   localparam logic [2:0] FN_TICK       = 3'd3;
   localparam logic [2:0] FN_DONE       = 3'd4;

   // Result status codes.
   localparam logic [2:0] ST_QUEUED     = 3'd0;
   localparam logic [2:0] ST_DUP        = 3'd1;
   localparam logic [2:0] ST_CANCELLED  = 3'd2;
   localparam logic [2:0] ST_NOTFOUND   = 3'd3;
   localparam logic [2:0] ST_CLEARED    = 3'd4;
   localparam logic [2:0] ST_DISPATCHED = 3'd5;
   localparam logic [2:0] ST_FINISHED   = 3'd6;
   localparam logic [2:0] ST_NOTHING    = 3'd7;

   // Register indexes.
   localparam logic [1:0] REG_DEDUP    = 2'd0;
   localparam logic [1:0] REG_MAXQ     = 2'd1;
   localparam logic [1:0] REG_DEBOUNCE = 2'd2;
   localparam logic [1:0] REG_RETRY    = 2'd3;

   // Register reset values.
   localparam logic        DEDUP_RESET    = 1'b1;
   localparam logic [4:0]  MAXQ_RESET     = 5'd16;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd100;
   localparam logic [15:0] RETRY_RESET    = 16'd10;

   typedef enum logic [1:0] {
      SCAN_MATCH,
      SCAN_MIN,
      SCAN_MAX
   } scan_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_APPEND,
      S_RESP
   } state_type;

   // Search record that walks down the row of cells.
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [IDX_W-1:0]   idx;
      logic signed [15:0] prio;
      logic [31:0]        id;
   } scan_rec_type;

   // Control broadcast to every cell.
   typedef struct packed {
      scan_mode_type      mode;
      logic [31:0]        key;
      logic [CNT_W-1:0]   fill;
      logic               shift_en;
      logic [IDX_W-1:0]   shift_pos;
      logic               load_en;
      logic [IDX_W-1:0]   load_pos;
      logic [31:0]        load_id;
      logic signed [15:0] load_prio;
   } cell_ctrl_type;

endpackage

`default_nettype wire

@@ design/prs_cell.sv @@
//------------------------------------------------------------------------------
// prs_cell
// One queue slot: holds an entry, refines the passing search record, and
// takes its neighbor's entry when the queue closes a gap.
//------------------------------------------------------------------------------
`default_nettype none

module prs_cell #(
   parameter int INDEX = 0
) (
   input  wire                       clock,
   input  wire                       reset,
   input  prs_pkg::cell_ctrl_type    ctrl,
   input  prs_pkg::scan_rec_type     scan_in,
   output prs_pkg::scan_rec_type     scan_out,
   input  wire [31:0]                next_id,
   input  wire signed [15:0]         next_prio,
   output logic [31:0]               ent_id,
   output logic signed [15:0]        ent_prio
);
   import prs_pkg::*;

   localparam logic [CNT_W-1:0] POS = CNT_W'(INDEX);

   logic [31:0]        id_ff;
   logic signed [15:0] prio_ff;
   scan_rec_type       rec_ff;
   scan_rec_type       rec_in;
   logic               occupied;

   assign occupied = POS < ctrl.fill;

   // Compare this slot against the record handed in from the left.
   always_comb begin
      rec_in = scan_in;
      if (scan_in.valid && occupied) begin
         case (ctrl.mode)
            SCAN_MATCH: begin
               if (!scan_in.found && id_ff == ctrl.key) begin
                  rec_in.found = 1'b1;
                  rec_in.idx   = POS[IDX_W-1:0];
                  rec_in.id    = id_ff;
                  rec_in.prio  = prio_ff;
               end
            end
            SCAN_MIN: begin
               if (!scan_in.found || prio_ff < scan_in.prio) begin
                  rec_in.found = 1'b1;
                  rec_in.idx   = POS[IDX_W-1:0];
                  rec_in.id    = id_ff;
                  rec_in.prio  = prio_ff;
               end
            end
            SCAN_MAX: begin
               if (!scan_in.found || prio_ff > scan_in.prio) begin
                  rec_in.found = 1'b1;
                  rec_in.idx   = POS[IDX_W-1:0];
                  rec_in.id    = id_ff;
                  rec_in.prio  = prio_ff;
               end
            end
            default: rec_in = scan_in;
         endcase
      end
   end

   // Record stage toward the right neighbor.
   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.valid <= 1'b0;
      end else begin
         rec_ff.valid <= rec_in.valid;
      end
      rec_ff.found <= rec_in.found;
      rec_ff.idx   <= rec_in.idx;
      rec_ff.prio  <= rec_in.prio;
      rec_ff.id    <= rec_in.id;
   end

   // Entry storage: load a new entry, or shift left to close a gap.
   always_ff @(posedge clock) begin
      if (ctrl.load_en && ctrl.load_pos == POS[IDX_W-1:0]) begin
         id_ff   <= ctrl.load_id;
         prio_ff <= ctrl.load_prio;
      end else if (ctrl.shift_en && POS[IDX_W-1:0] >= ctrl.shift_pos) begin
         id_ff   <= next_id;
         prio_ff <= next_prio;
      end
   end

   assign scan_out = rec_ff;
   assign ent_id   = id_ff;
   assign ent_prio = prio_ff;

endmodule

`default_nettype wire

@@ design/priority_request_scheduler.sv @@
//------------------------------------------------------------------------------
// priority_request_scheduler
// Bounded request queue in arrival order with one job in service, built as a
// row of slot cells that a search record walks through.
//
// Channel   Dir  Fields
// req_      in   tuser: func; tdata: req_id, req_priority
// rsp_      out  tuser: status; tdata: evicted, dispatch, pending, busy, finished
// csr_      in   plain register write
//
// Cancel-all, done and ticks without dispatch go from decode straight to response.
// A search walks the record through every cell register of the row; a submit
// may run a duplicate search, an eviction search and an append, in that order.
// Reset is synchronous; queue slots keep stale data, the fill count gates them.
// A stalled result holds the block in its response state until taken.
//------------------------------------------------------------------------------
`default_nettype none

module priority_request_scheduler #(
   parameter int DEPTH = prs_pkg::DEPTH_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [2:0]   req_tuser,   // [2:0] func
   input  wire  [47:0]  req_tdata,   // [31:0] req_id, [47:32] req_priority
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [2:0]   rsp_tuser,   // [2:0] status
   // [0] evicted_valid, [32:1] evicted_id, [33] dispatch_valid, [65:34] dispatch_id,
   // [70:66] pending_count, [71] busy_flag, [103:72] finished_id
   output logic [103:0] rsp_tdata,
   input  wire          csr_we,
   input  wire  [1:0]   csr_addr,
   input  wire  [15:0]  csr_wdata
);
   import prs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   // Configuration registers.
   logic        dedup_ff;
   logic [4:0]  maxq_ff;
   logic [15:0] deb_ticks_ff;
   logic [15:0] retry_ticks_ff;

   // Control state.
   state_type     state_ff, state_in;
   scan_mode_type mode_ff, mode_in;
   logic          start_ff, start_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          busy_ff, busy_in;
   logic [31:0]   serving_ff, serving_in;
   logic [31:0]   done_id_ff, done_id_in;
   logic [15:0]   deb_left_ff, deb_left_in;
   logic          deb_armed_ff, deb_armed_in;
   logic [15:0]   retry_left_ff, retry_left_in;
   logic          retry_armed_ff, retry_armed_in;

   // Latched item and result under construction.
   logic [2:0]         func_ff;
   logic [31:0]        id_ff;
   logic signed [15:0] prio_ff;
   logic [2:0]         st_ff, st_in;
   logic               evv_ff, evv_in;
   logic [31:0]        evid_ff, evid_in;
   logic               disv_ff, disv_in;
   logic [31:0]        disid_ff, disid_in;

   // Output register.
   logic         rsp_valid_ff;
   logic [2:0]   rsp_user_ff;
   logic [103:0] rsp_data_ff;
   logic         rsp_load;

   // Cell row.
   cell_ctrl_type      ctrl;
   scan_rec_type       rec [DEPTH+1];
   logic [31:0]        ent_id [DEPTH];
   logic signed [15:0] ent_prio [DEPTH];
   scan_rec_type       tail;

   logic          req_accept;
   logic [CW-1:0] cap;
   logic          full;
   logic          deb_fire, retry_fire, do_dispatch;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = state_ff == S_IDLE;
   assign tail       = rec[DEPTH];
   assign rsp_load   = state_ff == S_RESP && (!rsp_valid_ff || rsp_tready);

   // Capacity in use, clamped to 1..DEPTH.
   always_comb begin
      if (maxq_ff == 5'd0) begin
         cap = CW'(1);
      end else if (int'(maxq_ff) > DEPTH) begin
         cap = CW'(DEPTH);
      end else begin
         cap = CW'(maxq_ff);
      end
   end

   assign full        = fill_ff >= cap;
   assign deb_fire    = deb_armed_ff && deb_left_ff <= 16'd1;
   assign retry_fire  = retry_armed_ff && retry_left_ff <= 16'd1;
   assign do_dispatch = (deb_fire || retry_fire) && !busy_ff && fill_ff != '0;

   // Row of slot cells; the search record enters at slot zero.
   assign rec[0] = '{valid: start_ff, found: 1'b0, idx: '0, prio: '0, id: '0};

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      prs_cell #(.INDEX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .scan_in   (rec[k]),
         .scan_out  (rec[k+1]),
         .next_id   (ent_id[(k + 1 < DEPTH) ? k + 1 : k]),
         .next_prio (ent_prio[(k + 1 < DEPTH) ? k + 1 : k]),
         .ent_id    (ent_id[k]),
         .ent_prio  (ent_prio[k])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) state_in = S_DECODE;
         end
         S_DECODE: begin
            case (func_ff)
               FN_SUBMIT: begin
                  if (dedup_ff || full) state_in = S_SCAN;
                  else state_in = S_APPEND;
               end
               FN_CANCEL: state_in = S_SCAN;
               FN_TICK:   state_in = do_dispatch ? S_SCAN : S_RESP;
               default:   state_in = S_RESP;
            endcase
         end
         S_SCAN: begin
            if (tail.valid) begin
               case (mode_ff)
                  SCAN_MATCH: begin
                     if (func_ff != FN_SUBMIT || tail.found) state_in = S_RESP;
                     else if (full) state_in = S_SCAN;
                     else state_in = S_APPEND;
                  end
                  SCAN_MIN: state_in = S_APPEND;
                  default:  state_in = S_RESP;
               endcase
            end
         end
         S_APPEND: state_in = S_RESP;
         S_RESP: begin
            if (rsp_load) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and cell control.
   always_comb begin
      mode_in        = mode_ff;
      start_in       = 1'b0;
      fill_in        = fill_ff;
      busy_in        = busy_ff;
      serving_in     = serving_ff;
      done_id_in     = done_id_ff;
      deb_left_in    = deb_left_ff;
      deb_armed_in   = deb_armed_ff;
      retry_left_in  = retry_left_ff;
      retry_armed_in = retry_armed_ff;
      st_in          = st_ff;
      evv_in         = evv_ff;
      evid_in        = evid_ff;
      disv_in        = disv_ff;
      disid_in       = disid_ff;

      ctrl.mode      = mode_ff;
      ctrl.key       = id_ff;
      ctrl.fill      = CNT_W'(fill_ff);
      ctrl.shift_en  = 1'b0;
      ctrl.shift_pos = tail.idx;
      ctrl.load_en   = 1'b0;
      ctrl.load_pos  = IDX_W'(fill_ff);
      ctrl.load_id   = id_ff;
      ctrl.load_prio = prio_ff;

      case (state_ff)
         S_DECODE: begin
            st_in   = ST_NOTHING;
            evv_in  = 1'b0;
            evid_in = '0;
            disv_in = 1'b0;
            disid_in = '0;
            case (func_ff)
               FN_SUBMIT: begin
                  if (dedup_ff) begin
                     mode_in  = SCAN_MATCH;
                     start_in = 1'b1;
                  end else if (full) begin
                     mode_in  = SCAN_MIN;
                     start_in = 1'b1;
                  end
               end
               FN_CANCEL: begin
                  mode_in  = SCAN_MATCH;
                  start_in = 1'b1;
               end
               FN_CANCEL_ALL: begin
                  if (fill_ff != '0) begin
                     fill_in      = '0;
                     deb_armed_in = 1'b0;
                     deb_left_in  = '0;
                     st_in        = ST_CLEARED;
                  end
               end
               FN_TICK: begin
                  // Both countdowns advance; either expiring allows a dispatch.
                  if (deb_armed_ff) begin
                     if (deb_fire) begin
                        deb_left_in  = '0;
                        deb_armed_in = 1'b0;
                     end else begin
                        deb_left_in = deb_left_ff - 16'd1;
                     end
                  end
                  if (retry_armed_ff) begin
                     if (retry_fire) begin
                        retry_left_in  = '0;
                        retry_armed_in = 1'b0;
                     end else begin
                        retry_left_in = retry_left_ff - 16'd1;
                     end
                  end
                  if (do_dispatch) begin
                     mode_in  = SCAN_MAX;
                     start_in = 1'b1;
                  end
               end
               FN_DONE: begin
                  if (busy_ff) begin
                     done_id_in = serving_ff;
                     busy_in    = 1'b0;
                     st_in      = ST_FINISHED;
                     if (fill_ff != '0) begin
                        retry_left_in  = retry_ticks_ff;
                        retry_armed_in = 1'b1;
                     end
                  end
               end
               default: st_in = ST_NOTHING;
            endcase
         end
         S_SCAN: begin
            if (tail.valid) begin
               case (mode_ff)
                  SCAN_MATCH: begin
                     if (func_ff == FN_SUBMIT) begin
                        if (tail.found) begin
                           st_in = ST_DUP;
                        end else if (full) begin
                           mode_in  = SCAN_MIN;
                           start_in = 1'b1;
                        end
                     end else if (tail.found) begin
                        ctrl.shift_en = 1'b1;
                        fill_in       = fill_ff - CW'(1);
                        st_in         = ST_CANCELLED;
                     end else begin
                        st_in = ST_NOTFOUND;
                     end
                  end
                  SCAN_MIN: begin
                     // Evict the earliest lowest-priority entry.
                     ctrl.shift_en = 1'b1;
                     fill_in       = fill_ff - CW'(1);
                     evv_in        = 1'b1;
                     evid_in       = tail.id;
                  end
                  default: begin
                     // Dispatch the earliest highest-priority entry.
                     ctrl.shift_en = 1'b1;
                     fill_in       = fill_ff - CW'(1);
                     disv_in       = 1'b1;
                     disid_in      = tail.id;
                     busy_in       = 1'b1;
                     serving_in    = tail.id;
                     st_in         = ST_DISPATCHED;
                  end
               endcase
            end
         end
         S_APPEND: begin
            ctrl.load_en = 1'b1;
            fill_in      = fill_ff + CW'(1);
            deb_left_in  = deb_ticks_ff;
            deb_armed_in = 1'b1;
            st_in        = ST_QUEUED;
         end
         default: begin
            start_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         mode_ff        <= SCAN_MATCH;
         start_ff       <= 1'b0;
         fill_ff        <= '0;
         busy_ff        <= 1'b0;
         serving_ff     <= '0;
         done_id_ff     <= '0;
         deb_left_ff    <= '0;
         deb_armed_ff   <= 1'b0;
         retry_left_ff  <= '0;
         retry_armed_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         mode_ff        <= mode_in;
         start_ff       <= start_in;
         fill_ff        <= fill_in;
         busy_ff        <= busy_in;
         serving_ff     <= serving_in;
         done_id_ff     <= done_id_in;
         deb_left_ff    <= deb_left_in;
         deb_armed_ff   <= deb_armed_in;
         retry_left_ff  <= retry_left_in;
         retry_armed_ff <= retry_armed_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         dedup_ff       <= DEDUP_RESET;
         maxq_ff        <= MAXQ_RESET;
         deb_ticks_ff   <= DEBOUNCE_RESET;
         retry_ticks_ff <= RETRY_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_DEDUP:    dedup_ff <= csr_wdata[0];
            REG_MAXQ:     if (fill_ff == '0) maxq_ff <= csr_wdata[4:0];
            REG_DEBOUNCE: deb_ticks_ff <= csr_wdata;
            REG_RETRY:    retry_ticks_ff <= csr_wdata;
            default:      dedup_ff <= dedup_ff;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff <= req_tuser;
         id_ff   <= req_tdata[31:0];
         prio_ff <= req_tdata[47:32];
      end
      st_ff    <= st_in;
      evv_ff   <= evv_in;
      evid_ff  <= evid_in;
      disv_ff  <= disv_in;
      disid_ff <= disid_in;
      if (rsp_load) begin
         rsp_user_ff <= st_ff;
         rsp_data_ff <= {done_id_ff, busy_ff, 5'(fill_ff), disid_ff, disv_ff, evid_ff, evv_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "assert_macros.svh"

   `ASSERT_SAME(a_fill_bound, clock, reset, 1'b1, fill_ff <= cap)
   `ASSERT_NEXT(a_accept_decode, clock, reset, req_accept, state_ff == S_DECODE)
   `ASSERT_SAME(a_tail_in_scan, clock, reset, tail.valid, state_ff == S_SCAN)

endmodule

`default_nettype wire
